// File: rtl/core/bfcp_pkg.sv
// Package: shared constants, reply codes and the parser result type.
package bfcp_pkg;

  localparam int unsigned BufDepth = 10;
  localparam int unsigned CntW     = $clog2(BufDepth + 1);
  localparam int unsigned IdxW     = $clog2(BufDepth);

  localparam logic [7:0] ChOpen  = 8'h7B;
  localparam logic [7:0] ChClose = 8'h7D;
  localparam logic [7:0] ChP     = 8'h50;
  localparam logic [7:0] ChI     = 8'h49;
  localparam logic [7:0] ChN     = 8'h4E;
  localparam logic [7:0] ChS     = 8'h53;
  localparam logic [7:0] ChO     = 8'h4F;
  localparam logic [7:0] ChF     = 8'h46;
  localparam logic [7:0] ChL     = 8'h4C;
  localparam logic [7:0] ChE     = 8'h45;
  localparam logic [7:0] ChA     = 8'h41;
  localparam logic [7:0] ChD     = 8'h44;
  localparam logic [7:0] ChC     = 8'h43;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChOne   = 8'h31;

  typedef enum logic [2:0] {
    ReplyNone  = 3'd0,
    ReplyOn    = 3'd1,
    ReplyOff   = 3'd2,
    ReplyAdc   = 3'd3,
    ReplyError = 3'd4
  } reply_e;

  typedef struct packed {
    logic       has_result;
    reply_e     reply;
    logic [1:0] pin_levels;
  } bfcp_res_t;

endpackage

// File: rtl/core/brace_framed_command_parser_core.sv
// Top level: input register, frame parser and output register.
// A result is written to the output register when its item leaves the input register.
// Throughput: one item per cycle; the input stage advances whenever the item
// gives no result or the output register is empty or being drained.
// Reset: asynchronous, active low; clears both stage valids, the frame state,
// the byte count, the payload buffer and the pin levels.
module brace_framed_command_parser_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] rx_byte
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // [2:0] reply, [4:3] pin_levels, [7:5] zero
);
  import bfcp_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  reply_e     out_reply_q;
  logic [1:0] out_pins_q;
  logic       out_free, fire, take_in;
  bfcp_res_t  res;

  bfcp_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign fire            = in_valid_q && (!res.has_result || out_free);
  assign s_axis_tready_o = !in_valid_q || fire;
  assign take_in         = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take_in) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire && res.has_result) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_in) begin
      in_byte_q <= s_axis_tdata_i;
    end
    if (fire && res.has_result) begin
      out_reply_q <= res.reply;
      out_pins_q  <= res.pin_levels;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {3'b000, out_pins_q, out_reply_q};

  a_reply_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_reply_q == ReplyNone) || (out_reply_q == ReplyOn) ||
                    (out_reply_q == ReplyOff) || (out_reply_q == ReplyAdc) ||
                    (out_reply_q == ReplyError))
    else $error("result holds an undefined reply code");

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !fire |=> in_valid_q && $stable(in_byte_q))
    else $error("stalled input stage lost its item");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && res.has_result |-> out_free)
    else $error("result written over a pending result");

endmodule

// File: rtl/core/bfcp_parser.sv
// Frame parser: frame state, payload buffer, pin state and command decode.
module bfcp_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 fire_i,
  input  logic [7:0]           byte_i,
  output bfcp_pkg::bfcp_res_t  res_o
);
  import bfcp_pkg::*;

  logic             in_frame_q, in_frame_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [1:0]       pins_q, pins_d;
  logic [7:0]       buf_q [BufDepth];

  logic       is_open, is_close, is_store, is_ovf;
  logic       pin_cmd, adc_cmd, pin_known;
  logic [1:0] mask;
  reply_e     dec_reply;
  logic [1:0] dec_pins;

  always_comb begin
    pin_cmd   = (buf_q[0] == ChP) && (buf_q[1] == ChI) && (buf_q[2] == ChN);
    adc_cmd   = (buf_q[0] == ChL) && (buf_q[1] == ChE) && (buf_q[2] == ChA) &&
                (buf_q[3] == ChD) && (buf_q[4] == ChC);
    pin_known = (buf_q[3] == ChZero) || (buf_q[3] == ChOne);
    mask      = (buf_q[3] == ChZero) ? 2'b01 : 2'b10;
    dec_reply = ReplyNone;
    dec_pins  = pins_q;
    if (pin_cmd) begin
      if (pin_known) begin
        if (buf_q[4] == ChS) begin
          dec_reply = ((pins_q & mask) != 2'b00) ? ReplyOn : ReplyOff;
        end else if ((buf_q[4] == ChO) && (buf_q[5] == ChN)) begin
          dec_pins = pins_q | mask;
        end else if ((buf_q[4] == ChO) && (buf_q[5] == ChF) && (buf_q[6] == ChF)) begin
          dec_pins = pins_q & ~mask;
        end
      end
    end else if (adc_cmd) begin
      dec_reply = ReplyAdc;
    end
  end

  always_comb begin
    is_open  = (byte_i == ChOpen) && !in_frame_q;
    is_close = !is_open && (byte_i == ChClose) && in_frame_q;
    is_store = !is_open && !is_close && in_frame_q &&
               (count_q < CntW'(BufDepth));
    is_ovf   = !is_open && !is_close && !is_store &&
               (count_q >= CntW'(BufDepth));

    in_frame_d = in_frame_q;
    count_d    = count_q;
    pins_d     = pins_q;
    res_o.has_result = is_close || is_ovf;
    res_o.reply      = ReplyNone;
    res_o.pin_levels = pins_q;
    if (is_open) begin
      in_frame_d = 1'b1;
      count_d    = '0;
    end else if (is_close) begin
      in_frame_d       = 1'b0;
      pins_d           = dec_pins;
      res_o.reply      = dec_reply;
      res_o.pin_levels = dec_pins;
    end else if (is_store) begin
      count_d = count_q + CntW'(1);
    end else if (is_ovf) begin
      in_frame_d  = 1'b0;
      count_d     = '0;
      res_o.reply = ReplyError;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      count_q    <= '0;
      pins_q     <= 2'b00;
    end else if (fire_i) begin
      in_frame_q <= in_frame_d;
      count_q    <= count_d;
      pins_q     <= pins_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q <= '{default: '0};
    end else if (fire_i && is_store) begin
      buf_q[count_q[IdxW-1:0]] <= byte_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(BufDepth))
    else $error("byte count above buffer depth");

  a_ovf_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && is_ovf |=> (count_q == '0) && !in_frame_q)
    else $error("overflow did not clear frame state");

  a_open_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && is_open |=> in_frame_q && (count_q == '0))
    else $error("opening brace did not start a frame");

endmodule

// File: sim/brace_framed_command_parser_core_tb.sv
// Testbench for the brace-framed command parser core: byte stream in, checked replies out.
`timescale 1ns / 100ps

module brace_framed_command_parser_core_tb;
  import bfcp_pkg::*;

  localparam int unsigned ItemTarget = 1350;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PrintCap   = 20;

  typedef struct packed {
    reply_e     reply;
    logic [1:0] pins;
  } parser_reply_t;

  class parser_scoreboard;
    logic          in_frame;
    int unsigned   fill;
    logic [7:0]    payload [BufDepth];
    logic [1:0]    pin_state;
    parser_reply_t replies_due [$];
    int unsigned   tally [5];

    function new();
      in_frame  = 1'b0;
      fill      = 0;
      pin_state = 2'b00;
      foreach (payload[i]) payload[i] = 8'h00;
      foreach (tally[i]) tally[i] = 0;
    endfunction

    function logic [7:0] slot(int unsigned pos);
      return (pos < BufDepth) ? payload[pos] : 8'h00;
    endfunction

    function reply_e decode_payload();
      logic [1:0] mask;
      if (slot(0) == ChP && slot(1) == ChI && slot(2) == ChN) begin
        if (slot(3) == ChZero) mask = 2'b01;
        else if (slot(3) == ChOne) mask = 2'b10;
        else return ReplyNone;
        if (slot(4) == ChS) return ((pin_state & mask) != 2'b00) ? ReplyOn : ReplyOff;
        if (slot(4) == ChO && slot(5) == ChN) begin
          pin_state = pin_state | mask;
          return ReplyNone;
        end
        if (slot(4) == ChO && slot(5) == ChF && slot(6) == ChF) pin_state = pin_state & ~mask;
        return ReplyNone;
      end
      if (slot(0) == ChL && slot(1) == ChE && slot(2) == ChA && slot(3) == ChD && slot(4) == ChC)
        return ReplyAdc;
      return ReplyNone;
    endfunction

    function void note_byte(logic [7:0] b);
      parser_reply_t r;
      bit            has;
      has = 1'b0;
      if (b == ChOpen && !in_frame) begin
        in_frame = 1'b1;
        fill     = 0;
        return;
      end
      if (b == ChClose && in_frame) begin
        in_frame = 1'b0;
        r.reply  = decode_payload();
        has      = 1'b1;
      end else if (in_frame && fill < BufDepth) begin
        payload[fill] = b;
        fill++;
      end else if (fill >= BufDepth) begin
        in_frame = 1'b0;
        fill     = 0;
        r.reply  = ReplyError;
        has      = 1'b1;
      end
      if (has) begin
        r.pins = pin_state;
        replies_due.push_back(r);
      end
    endfunction

    function bit check_reply(logic [7:0] word, output string msg);
      parser_reply_t e;
      msg = "";
      if (replies_due.size() == 0) begin
        $sformat(msg, "unexpected result 0x%02h", word);
        return 1'b0;
      end
      e = replies_due.pop_front();
      if (e.reply <= ReplyError) tally[e.reply]++;
      if (word[2:0] !== e.reply || word[4:3] !== e.pins || word[7:5] !== 3'b000) begin
        $sformat(msg, "result 0x%02h: reply %0d pins %b, wanted reply %0d pins %b",
                 word, word[2:0], word[4:3], e.reply, e.pins);
        return 1'b0;
      end
      return 1'b1;
    endfunction

    function int unsigned pending();
      return replies_due.size();
    endfunction
  endclass

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       s_tvalid = 1'b0;
  logic [7:0] s_tdata = 8'h00;
  logic       m_tready = 1'b0;
  logic       s_axis_tready_o;
  logic       m_axis_tvalid_o;
  logic [7:0] m_axis_tdata_o;

  parser_scoreboard sb = new();

  int unsigned errors = 0;
  int unsigned items_sent = 0;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;
  int unsigned hold_req = 0;
  int unsigned hold_ack = 0;
  int unsigned hold_left = 0;
  bit          idle_on = 1'b1;

  brace_framed_command_parser_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),        // [7:0] rx_byte
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_axis_tdata_o)  // [2:0] reply, [4:3] pin_levels, [7:5] zero
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic report_mismatch(string msg);
    if (errors < PrintCap) $display("ERROR: %s", msg);
    errors++;
  endtask

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL brace_framed_command_parser_core");
      $finish;
    end
  end

  always @(posedge clk_i) begin : result_side
    string msg;
    if (m_axis_tvalid_o && m_tready) begin
      if (!sb.check_reply(m_axis_tdata_o, msg)) report_mismatch(msg);
      results_seen++;
    end
    if (hold_req != hold_ack) begin
      hold_ack  <= hold_req;
      hold_left <= HoldCycles;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else if (idle_on && $urandom_range(0, 99) < 17) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic send_byte(logic [7:0] b);
    if (idle_on && $urandom_range(0, 99) < 20) begin
      s_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    do @(posedge clk_i); while (!(s_tvalid && s_axis_tready_o));
    sb.note_byte(b);
    items_sent++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic send_random_frame();
    logic [7:0] q [$];
    logic [7:0] letters [13];
    int unsigned kind;
    int unsigned len;
    letters = '{ChP, ChI, ChN, ChS, ChO, ChF, ChL, ChE, ChA, ChD, ChC, ChZero, ChOne};
    kind = $urandom_range(0, 99);
    if (kind < 55) begin
      q.push_back(ChOpen);
      if ($urandom_range(0, 4) == 0) begin
        q = {q, ChL, ChE, ChA, ChD, ChC};
      end else begin
        q = {q, ChP, ChI, ChN};
        if ($urandom_range(0, 7) == 0) q.push_back(8'($urandom_range(0, 255)));
        else q.push_back($urandom_range(0, 1) ? ChOne : ChZero);
        case ($urandom_range(0, 2))
          0: q.push_back(ChS);
          1: q = {q, ChO, ChN};
          default: q = {q, ChO, ChF, ChF};
        endcase
      end
      if ($urandom_range(0, 9) == 0) q[$urandom_range(1, q.size() - 1)] = 8'($urandom_range(0, 255));
      q.push_back(ChClose);
    end else if (kind < 65) begin
      q.push_back(ChOpen);
      len = $urandom_range(0, 4);
      repeat (len) q.push_back(letters[$urandom_range(0, 12)]);
      q.push_back(ChClose);
    end else if (kind < 77) begin
      q.push_back(ChOpen);
      len = $urandom_range(BufDepth - 1, BufDepth + 2);
      repeat (len) q.push_back(8'($urandom_range(0, 255)));
      q.push_back(ChClose);
      if ($urandom_range(0, 1)) q.push_back(8'($urandom_range(0, 255)));
    end else begin
      len = $urandom_range(1, 3);
      repeat (len) q.push_back(8'($urandom_range(0, 255)));
    end
    foreach (q[i]) send_byte(q[i]);
  endtask

  initial begin
    int unsigned frame_no;
    int unsigned bursts;
    frame_no = 0;
    bursts   = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_text("{PIN0ON}{PIN0S}{PIN1S}{PIN1ON}{PIN1S}{PIN0OFF}{PIN0S}");
    send_text("{LEADC}{PIN7S}{}{PIN1}{{}}xy{PIN0ON}{PIN0}");
    send_text("{ABCDEFGHIJK}{0123456789}Z");
    send_byte(ChOpen);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(ChClose);
    drain();

    while (items_sent < ItemTarget) begin
      idle_on = !(items_sent >= 700 && items_sent < 900);
      if ((bursts == 0 && items_sent > 400) || (bursts == 1 && items_sent > 1050)) begin
        hold_req++;
        bursts++;
        repeat (16) send_text("{LEADC}");
      end
      if (frame_no == 60) drain();
      send_random_frame();
      frame_no++;
    end
    idle_on = 1'b1;

    drain();
    repeat (8) @(posedge clk_i);
    if (sb.pending() != 0) report_mismatch($sformatf("%0d results never arrived", sb.pending()));

    $display("Sent %0d bytes, checked %0d results in %0d cycles", items_sent, results_seen,
             cycle_count);
    $display("Replies: none %0d, on %0d, off %0d, adc %0d, overflow %0d", sb.tally[ReplyNone],
             sb.tally[ReplyOn], sb.tally[ReplyOff], sb.tally[ReplyAdc], sb.tally[ReplyError]);
    if (errors == 0) begin
      $display("PASS brace_framed_command_parser_core");
    end else begin
      $display("FAIL brace_framed_command_parser_core");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/bfcp_pkg.sv
rtl/core/bfcp_parser.sv
rtl/core/brace_framed_command_parser_core.sv
sim/brace_framed_command_parser_core_tb.sv
